// ----- rtl/core/vic_pkg.sv -----
// Shared types and constants of the vectored interrupt controller.
package vic_pkg;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_LINE  = 2'd2
   } func_type;

   localparam logic [5:0] W_ENABLE     = 6'd32;
   localparam logic [5:0] W_ENABLE_SET = 6'd33;
   localparam logic [5:0] W_ENABLE_CLR = 6'd34;
   localparam logic [5:0] W_PENDING    = 6'd35;
   localparam logic [5:0] W_RAW        = 6'd36;
   localparam logic [5:0] W_SOFT       = 6'd37;
   localparam logic [5:0] W_SOFT_SET   = 6'd38;
   localparam logic [5:0] W_SOFT_CLR   = 6'd39;
   localparam logic [5:0] W_CTRL       = 6'd40;
   localparam logic [5:0] W_STATUS     = 6'd41;
   localparam logic [5:0] W_BASE       = 6'd42;
   localparam logic [5:0] W_VADDR      = 6'd43;

   localparam int          CFG_WIDTH   = 13;
   localparam int          CTRL_WIDTH  = 4;
   localparam logic [31:0] STATUS_FLAG = 32'h8000_0000;

   typedef struct packed {
      logic        irq_out;
      logic [31:0] read_data;
   } rsp_type;

endpackage

// ----- rtl/core/vectored_interrupt_controller.sv -----
// Vectored interrupt controller: per-source config RAM, masks and vector logic.
//
// Every accepted item (bus read, bus write or line level change) yields one
// response, registered in stage one and then in the response queue, and a new
// item can be taken in every cycle while the queue has room. The per-source
// config words live in a RAM with a registered read; writes land in the RAM
// at the transfer edge, so a read that follows in the next cycle already
// sees them. Per-entry valid flops make unwritten config words read as zero
// right after reset, with no clearing pass. Responses go through a four-entry
// queue, so the request side keeps taking items while results wait.
module vectored_interrupt_controller #(
   parameter int NUM_SOURCES = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_word_index,
   input  logic [31:0] req_write_data,
   input  logic [4:0]  req_line_number,
   input  logic        req_line_level,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_out
);

   localparam int SRC_AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic [31:0] SRC_MASK = (NUM_SOURCES >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << NUM_SOURCES) - 64'd1);
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int QCW    = 3;

   // Architectural registers.
   logic [31:0]                     enable_ff, enable_in;
   logic [31:0]                     soft_ff, soft_in;
   logic [31:0]                     line_ff, line_in;
   logic [vic_pkg::CTRL_WIDTH-1:0]  ctrl_ff, ctrl_in;
   logic [31:0]                     base_ff, base_in;
   logic [NUM_SOURCES-1:0]          cfg_valid_ff, cfg_valid_in;

   // Stage one: waiting on the RAM read data.
   logic        s1_valid_ff;
   logic        s1_cfg_ff;
   logic        s1_hit_ff;
   logic [31:0] s1_data_ff;
   logic        s1_irq_ff;
   logic        s1_hit_in;
   logic [31:0] s1_data_in;
   logic        s1_irq_in;

   // Response queue.
   vic_pkg::rsp_type q_data_ff [QDEPTH];
   logic [QAW-1:0]   q_head_ff, q_tail_ff;
   logic [QCW-1:0]   q_count_ff, q_count_in;
   vic_pkg::rsp_type push_rsp;

   logic                          req_fire;
   logic                          rsp_fire;
   vic_pkg::func_type             func;
   logic                          cfg_word;
   logic                          cfg_in_range;
   logic                          line_in_range;
   logic [SRC_AW-1:0]             cfg_addr;
   logic                          cfg_wr_en;
   logic [vic_pkg::CFG_WIDTH-1:0] cfg_rd_data;
   logic [31:0]                   pending_cur;
   logic [31:0]                   pending_nxt;
   logic [4:0]                    low_idx;
   logic                          found;
   logic [31:0]                   status_word;
   logic [31:0]                   vector_addr;

   assign func          = vic_pkg::func_type'(req_func);
   assign req_fire      = req_valid && req_ready;
   assign rsp_fire      = rsp_valid && rsp_ready;
   assign cfg_word      = !req_word_index[5];
   assign cfg_in_range  = cfg_word && ({1'b0, req_word_index[4:0]} < 6'(NUM_SOURCES));
   assign line_in_range = {1'b0, req_line_number} < 6'(NUM_SOURCES);
   assign cfg_addr      = req_word_index[SRC_AW-1:0];
   assign cfg_wr_en     = req_fire && (func == vic_pkg::FUNC_WRITE) && cfg_in_range;

   vic_ram #(
      .WIDTH(vic_pkg::CFG_WIDTH),
      .DEPTH(NUM_SOURCES)
   ) u_cfg_ram (
      .clock  (clock),
      .wr_en  (cfg_wr_en),
      .wr_addr(cfg_addr),
      .wr_data(req_write_data[vic_pkg::CFG_WIDTH-1:0]),
      .rd_en  (req_fire),
      .rd_addr(cfg_addr),
      .rd_data(cfg_rd_data)
   );

   // Priority encode of the current pending set, lowest index wins.
   always_comb begin
      pending_cur = (line_ff | soft_ff) & enable_ff & SRC_MASK;
      found       = |pending_cur;
      low_idx     = '0;
      for (int i = 31; i >= 0; i--) begin
         if (pending_cur[i]) begin
            low_idx = 5'(i);
         end
      end
      status_word = found ? (vic_pkg::STATUS_FLAG | 32'(low_idx)) : 32'd0;
      vector_addr = found ? (base_ff + (32'(low_idx) << (4'(ctrl_ff[2:0]) + 4'd2)))
                          : 32'd0;
   end

   // Register updates and the read value of non-RAM words.
   always_comb begin
      enable_in    = enable_ff;
      soft_in      = soft_ff;
      line_in      = line_ff;
      ctrl_in      = ctrl_ff;
      base_in      = base_ff;
      cfg_valid_in = cfg_valid_ff;
      s1_data_in   = 32'd0;
      s1_hit_in    = 1'b0;
      if (cfg_in_range) begin
         s1_hit_in = cfg_valid_ff[cfg_addr];
      end
      case (func)
         vic_pkg::FUNC_READ: begin
            unique case (req_word_index)
               vic_pkg::W_ENABLE:  s1_data_in = enable_ff;
               vic_pkg::W_PENDING: s1_data_in = pending_cur;
               vic_pkg::W_RAW:     s1_data_in = line_ff;
               vic_pkg::W_SOFT:    s1_data_in = soft_ff;
               vic_pkg::W_CTRL:    s1_data_in = 32'(ctrl_ff);
               vic_pkg::W_STATUS:  s1_data_in = status_word;
               vic_pkg::W_BASE:    s1_data_in = base_ff;
               vic_pkg::W_VADDR:   s1_data_in = vector_addr;
               default:            s1_data_in = 32'd0;
            endcase
         end
         vic_pkg::FUNC_WRITE: begin
            if (cfg_in_range) begin
               cfg_valid_in[cfg_addr] = 1'b1;
            end
            unique case (req_word_index)
               vic_pkg::W_ENABLE:     enable_in = req_write_data;
               vic_pkg::W_ENABLE_SET: enable_in = enable_ff | req_write_data;
               vic_pkg::W_ENABLE_CLR: enable_in = enable_ff & ~req_write_data;
               vic_pkg::W_SOFT:       soft_in   = req_write_data;
               vic_pkg::W_SOFT_SET:   soft_in   = soft_ff | req_write_data;
               vic_pkg::W_SOFT_CLR:   soft_in   = soft_ff & ~req_write_data;
               vic_pkg::W_CTRL:       ctrl_in   = req_write_data[vic_pkg::CTRL_WIDTH-1:0];
               vic_pkg::W_BASE:       base_in   = req_write_data;
               default:               ;
            endcase
         end
         vic_pkg::FUNC_LINE: begin
            if (line_in_range) begin
               line_in[req_line_number] = req_line_level;
            end
         end
         default: ;
      endcase
      pending_nxt = (line_in | soft_in) & enable_in & SRC_MASK;
      s1_irq_in   = |pending_nxt;
   end

   // The config read data joins the response as it enters the queue.
   always_comb begin
      push_rsp.irq_out   = s1_irq_ff;
      push_rsp.read_data = s1_data_ff;
      if (s1_cfg_ff) begin
         push_rsp.read_data = s1_hit_ff ? 32'(cfg_rd_data) : 32'd0;
      end
      q_count_in = q_count_ff + QCW'(s1_valid_ff) - QCW'(rsp_fire);
   end

   // Room is kept for the item in stage one as well as the new one.
   assign req_ready     = (q_count_ff + QCW'(s1_valid_ff)) < QCW'(QDEPTH);
   assign rsp_valid     = q_count_ff != '0;
   assign rsp_read_data = q_data_ff[q_head_ff].read_data;
   assign rsp_irq_out   = q_data_ff[q_head_ff].irq_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         soft_ff      <= '0;
         line_ff      <= '0;
         ctrl_ff      <= '0;
         base_ff      <= '0;
         cfg_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         q_count_ff   <= '0;
      end else begin
         if (req_fire) begin
            enable_ff    <= enable_in;
            soft_ff      <= soft_in;
            line_ff      <= line_in;
            ctrl_ff      <= ctrl_in;
            base_ff      <= base_in;
            cfg_valid_ff <= cfg_valid_in;
         end
         s1_valid_ff <= req_fire;
         if (s1_valid_ff) begin
            q_tail_ff <= q_tail_ff + QAW'(1);
         end
         if (rsp_fire) begin
            q_head_ff <= q_head_ff + QAW'(1);
         end
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cfg_ff  <= (func == vic_pkg::FUNC_READ) && cfg_word;
         s1_hit_ff  <= s1_hit_in;
         s1_data_ff <= s1_data_in;
         s1_irq_ff  <= s1_irq_in;
      end
      if (s1_valid_ff) begin
         q_data_ff[q_tail_ff] <= push_rsp;
      end
   end

endmodule

// ----- rtl/core/vic_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vic_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
